// File: sv/actr_pkg.sv
// Shared types, tables and round functions for the AES-128 counter-mode decrypt unit.
`default_nettype none
package actr_pkg;

	localparam int NumRounds = 10;

	localparam logic [0:255][7:0] SBOX = {
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [0:9][7:0] RCON = {
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// first key word takes a fixed mask, later words a strobe byte next to the running CRC
	localparam logic [31:0] CRC_MASK0 = 32'hAA55AA55;
	localparam logic [0:3][7:0] CRC_STROBE = {8'h00, 8'h03, 8'h18, 8'hC0};
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_XOR_OUT = 8'h55;

	typedef enum logic [2:0] {
		REG_KEY0    = 3'd0,
		REG_KEY1    = 3'd1,
		REG_KEY2    = 3'd2,
		REG_KEY3    = 3'd3,
		REG_NONCE   = 3'd4,
		REG_VERSION = 3'd5,
		REG_REGION  = 3'd6,
		REG_NONE    = 3'd7
	} reg_index_t;

	// data handed from cell to cell
	typedef struct packed {
		logic [127:0] state;
		logic [127:0] rkey;
		logic [127:0] cipher;
		logic [31:0]  kv;
		logic [7:0]   crc;
	} item_t;

	// CRC work assigned to a cell
	typedef struct packed {
		logic       active;
		logic       first_half;
		logic [1:0] word_sel;
	} crc_ctl_t;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tmp;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ tmp;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		key_expand = {w0, w1, w2, w3};
	endfunction

	function automatic logic [7:0] crc_shift16(input logic [7:0] crc_in, input logic [15:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc_in;
		for (int i = 15; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		crc_shift16 = c;
	endfunction

endpackage
`default_nettype wire

// File: sv/aes128_ctr_block_decrypt_unit.sv
// Top level of the AES-128 counter-mode block decrypt unit: registers, counter build, round chain.
// One 16-byte block enters per cycle whenever the front stage can take it: a front stage
// builds the counter block and adds the first round key, then ten round cells
// each expand the next round key and apply one AES round; the key check CRC is worked out
// sixteen bits per cell in the first eight cells. Every stage holds one block, and a stage
// that is empty takes a new one even while the output waits, so a stalled result backs up
// the chain only as far as it is full.
`default_nettype none
module aes128_ctr_block_decrypt_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [63:0]  wr_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// block_address, cipher_low, cipher_high
	input  wire logic [159:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// plain_low, plain_high, key_crc
	output logic [135:0]      m_axis_tdata
);
	import actr_pkg::*;

	logic [31:0] key_word_0_q, key_word_1_q, key_word_2_q, key_word_3_q;
	logic [63:0] nonce_q;
	logic [15:0] key_version_q;
	logic [2:0]  region_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_word_0_q  <= '0;
			key_word_1_q  <= '0;
			key_word_2_q  <= '0;
			key_word_3_q  <= '0;
			nonce_q       <= '0;
			key_version_q <= '0;
			region_id_q   <= 3'd1;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_KEY0:    key_word_0_q  <= wr_data[31:0];
				REG_KEY1:    key_word_1_q  <= wr_data[31:0];
				REG_KEY2:    key_word_2_q  <= wr_data[31:0];
				REG_KEY3:    key_word_3_q  <= wr_data[31:0];
				REG_NONCE:   nonce_q       <= wr_data;
				REG_VERSION: key_version_q <= wr_data[15:0];
				REG_REGION:  region_id_q   <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	logic [127:0] key;
	logic [1:0]   region_m1;
	logic [127:0] counter;
	logic [31:0]  cfg_key_word [4];

	assign key = {key_word_3_q, key_word_2_q, key_word_1_q, key_word_0_q};
	// out-of-range regions wrap modulo four
	assign region_m1 = 2'(region_id_q - 3'd1);
	assign counter = {nonce_q, 16'h0000, key_version_q, 2'b00, region_m1,
		s_axis_tdata[31:4]};
	assign cfg_key_word[0] = key_word_0_q;
	assign cfg_key_word[1] = key_word_1_q;
	assign cfg_key_word[2] = key_word_2_q;
	assign cfg_key_word[3] = key_word_3_q;

	logic  valid [NumRounds + 1];
	item_t item  [NumRounds + 1];
	logic  adv   [NumRounds + 1];

	always_comb begin
		adv[NumRounds] = !valid[NumRounds] || m_axis_tready;
		for (int i = NumRounds - 1; i >= 0; i--) begin
			adv[i] = !valid[i] || adv[i + 1];
		end
	end

	logic  valid_s1;
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv[0]) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			item_s1.state  <= counter ^ key;
			item_s1.rkey   <= key;
			item_s1.cipher <= s_axis_tdata[159:32];
			item_s1.kv     <= '0;
			item_s1.crc    <= '0;
		end
	end

	assign valid[0] = valid_s1;
	assign item[0]  = item_s1;

	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		crc_ctl_t ctl;
		assign ctl.active     = (r <= 8);
		assign ctl.first_half = ((r - 1) % 2 == 0);
		assign ctl.word_sel   = 2'(((r - 1) / 2) % 4);

		actr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (adv[r]),
			.in_valid   (valid[r - 1]),
			.in_item    (item[r - 1]),
			.rcon       (RCON[r - 1]),
			.last_round (r == NumRounds),
			.crc_ctl    (ctl),
			.key_word   (cfg_key_word[((r - 1) / 2) % 4]),
			.out_valid  (valid[r]),
			.out_item   (item[r])
		);
	end

	logic [127:0] plain;
	assign plain = item[NumRounds].cipher ^ item[NumRounds].state;

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = valid[NumRounds];
	assign m_axis_tdata  = {item[NumRounds].crc, plain};

endmodule
`default_nettype wire

// File: sv/actr_cell.sv
// One AES round cell: round key expansion, round transform and a slice of the key CRC.
`default_nettype none
module actr_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              in_valid,
	input  wire actr_pkg::item_t   in_item,
	input  wire logic [7:0]        rcon,
	input  wire logic              last_round,
	input  wire actr_pkg::crc_ctl_t crc_ctl,
	input  wire logic [31:0]       key_word,
	output logic                   out_valid,
	output actr_pkg::item_t        out_item
);
	import actr_pkg::*;

	logic        valid_q;
	item_t       item_q;
	item_t       nxt;
	logic [127:0] rk_next;
	logic [7:0]  sb [16];
	logic [7:0]  mx [16];
	logic [7:0]  a0, a1, a2, a3, all;
	logic [127:0] round_out;
	logic [7:0]  cs;
	logic [31:0] kv_load;

	always_comb begin
		rk_next = key_expand(in_item.rkey, rcon);
		// sub bytes with shift rows folded into the byte pick
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				sb[k + 4 * c] = SBOX[in_item.state[127 - 8 * (k + 4 * ((c + k) % 4)) -: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = sb[4 * c];
			a1 = sb[4 * c + 1];
			a2 = sb[4 * c + 2];
			a3 = sb[4 * c + 3];
			all = a0 ^ a1 ^ a2 ^ a3;
			mx[4 * c]     = last_round ? a0 : (a0 ^ all ^ xtime(a0 ^ a1));
			mx[4 * c + 1] = last_round ? a1 : (a1 ^ all ^ xtime(a1 ^ a2));
			mx[4 * c + 2] = last_round ? a2 : (a2 ^ all ^ xtime(a2 ^ a3));
			mx[4 * c + 3] = last_round ? a3 : (a3 ^ all ^ xtime(a3 ^ a0));
		end
		for (int i = 0; i < 16; i++) begin
			round_out[127 - 8 * i -: 8] = mx[i] ^ rk_next[127 - 8 * i -: 8];
		end

		cs = CRC_STROBE[crc_ctl.word_sel];
		if (crc_ctl.word_sel == 2'd0) begin
			kv_load = key_word ^ CRC_MASK0;
		end else begin
			kv_load = key_word ^ {cs, in_item.crc, cs, in_item.crc};
		end

		nxt = in_item;
		nxt.state = round_out;
		nxt.rkey = rk_next;
		if (crc_ctl.active) begin
			if (crc_ctl.first_half) begin
				// restart the register on each word, high half first
				nxt.kv = kv_load;
				nxt.crc = crc_shift16(8'h00, kv_load[31:16]);
			end else begin
				nxt.crc = crc_shift16(in_item.crc, in_item.kv[15:0]) ^ CRC_XOR_OUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item = item_q;

endmodule
`default_nettype wire

// File: sv/actr_checker.sv
// Port-level checks on the decrypt unit, bound to its top level.
`default_nettype none
module actr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [135:0] m_axis_tdata
);

	// an open output means the whole chain moves, so a request is always taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input not ready while output side drains");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a waiting request must see a defined ready
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tready))
		else $error("ready unknown while request waits");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("result data unknown while valid");

endmodule

bind aes128_ctr_block_decrypt_unit actr_checker u_actr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking bench for the AES-128 counter-mode block decrypt unit with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import actr_pkg::*;

	typedef struct {
		logic [63:0] plain_low;
		logic [63:0] plain_high;
		logic [7:0]  key_crc;
	} plain_block_t;

	typedef struct {
		logic [31:0] addr;
		logic [63:0] cl;
		logic [63:0] ch;
	} cipher_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         wr_en = 1'b0;
	logic [2:0]   wr_index = '0;
	logic [63:0]  wr_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// block_address, cipher_low, cipher_high
	logic [159:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// plain_low, plain_high, key_crc
	logic [135:0] m_axis_tdata;

	// predictor copy of the registers
	logic [31:0] key_word [0:3];
	logic [63:0] nonce_q;
	logic [15:0] version_q;
	logic [2:0]  region_q;

	plain_block_t expected_plain[$];
	int errors = 0;
	int blocks_sent = 0;
	int blocks_seen = 0;
	int cfg_writes = 0;
	bit sink_eager = 0;

	aes128_ctr_block_decrypt_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes128_encrypt_block(input logic [127:0] key,
			input logic [127:0] blk);
		logic [7:0] rk [0:175];
		logic [7:0] s [0:15];
		logic [7:0] t [0:15];
		logic [7:0] a0, a1, a2, a3, all, tmp;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
		for (int i = 16; i < 176; i += 4) begin
			a0 = rk[i-4]; a1 = rk[i-3]; a2 = rk[i-2]; a3 = rk[i-1];
			if ((i % 16) == 0) begin
				tmp = a0;
				a0 = SBOX[a1] ^ RCON[i/16 - 1];
				a1 = SBOX[a2];
				a2 = SBOX[a3];
				a3 = SBOX[tmp];
			end
			rk[i] = rk[i-16] ^ a0;
			rk[i+1] = rk[i-15] ^ a1;
			rk[i+2] = rk[i-14] ^ a2;
			rk[i+3] = rk[i-13] ^ a3;
		end
		for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 4; k++)
					t[k+4*c] = SBOX[s[k + 4*((c+k) % 4)]];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c] = a0 ^ all ^ gf_double(a0 ^ a1);
					t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
					t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
					t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	// chained CRC-8 over the key words, word 0 first
	function automatic logic [7:0] key_check_crc();
		logic [31:0] kv;
		logic [7:0]  crc;
		logic [7:0]  stb;
		logic        fb;
		crc = 8'h00;
		for (int j = 0; j < 4; j++) begin
			stb = CRC_STROBE[j];
			if (j == 0)
				kv = key_word[0] ^ CRC_MASK0;
			else
				kv = key_word[j] ^ {stb, crc, stb, crc};
			crc = 8'h00;
			for (int i = 31; i >= 0; i--) begin
				fb = crc[7] ^ kv[i];
				crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			crc = crc ^ CRC_XOR_OUT;
		end
		return crc;
	endfunction

	function automatic plain_block_t decrypt_block(input cipher_row_t row);
		logic [127:0] ctr, ks;
		logic [1:0]   region_sel;
		plain_block_t p;
		region_sel = region_q[1:0] - 2'd1;
		ctr = {nonce_q, 16'h0000, version_q, 2'b00, region_sel, row.addr[31:4]};
		ks = aes128_encrypt_block({key_word[3], key_word[2], key_word[1], key_word[0]}, ctr);
		p.plain_low = row.cl ^ ks[63:0];
		p.plain_high = row.ch ^ ks[127:64];
		p.key_crc = key_check_crc();
		return p;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) return 0;
		if (roll < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// output side: random stalls, with eager stretches
	always @(posedge clk) begin
		if ($urandom_range(199) == 0) sink_eager <= ~sink_eager;
		m_axis_tready <= sink_eager ? 1'b1 : (pick_gap() == 0);
	end

	always @(posedge clk) begin
		plain_block_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			blocks_seen++;
			if (expected_plain.size() == 0) begin
				$error("unexpected block: plain_low %h", m_axis_tdata[63:0]);
				errors++;
			end else begin
				want = expected_plain.pop_front();
				if (m_axis_tdata[63:0] !== want.plain_low) begin
					$error("plain_low: expected %h, got %h", want.plain_low, m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== want.plain_high) begin
					$error("plain_high: expected %h, got %h", want.plain_high,
						m_axis_tdata[127:64]);
					errors++;
				end
				if (m_axis_tdata[135:128] !== want.key_crc) begin
					$error("key_crc: expected %h, got %h", want.key_crc, m_axis_tdata[135:128]);
					errors++;
				end
			end
		end
	end

	// hold the enable across back-to-back writes; the caller drops it
	task automatic write_reg(input reg_index_t idx, input logic [63:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			REG_KEY0: key_word[0] = data[31:0];
			REG_KEY1: key_word[1] = data[31:0];
			REG_KEY2: key_word[2] = data[31:0];
			REG_KEY3: key_word[3] = data[31:0];
			REG_NONCE: nonce_q = data;
			REG_VERSION: version_q = data[15:0];
			REG_REGION: region_q = data[2:0];
			default: ;
		endcase
	endtask

	// drop the request and drain the pipeline before touching registers
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_plain.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] k0, k1, k2, k3, nv, ver, reg_id);
		wait_idle();
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE, nv);
		write_reg(REG_VERSION, ver);
		write_reg(REG_REGION, reg_id);
		// unknown index must leave everything alone
		write_reg(REG_NONE, {$urandom, $urandom});
		wr_en <= 1'b0;
	endtask

	task automatic send_block(input cipher_row_t row, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row.ch, row.cl, row.addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_plain.push_back(decrypt_block(row));
		blocks_sent++;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	cipher_row_t directed_rows [0:7] = '{
		'{32'h0000_0000, 64'h0, 64'h0},
		'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
		'{32'h0000_000F, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
		'{32'h0000_0010, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
		'{32'hFFFF_FFF0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
		'{32'h8000_0000, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001},
		'{32'h0000_0017, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
		'{32'h7FFF_FFF8, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF}
	};

	initial begin
		cipher_row_t row;
		bit burst;
		key_word[0] = '0; key_word[1] = '0; key_word[2] = '0; key_word[3] = '0;
		nonce_q = '0;
		version_q = '0;
		region_q = 3'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values first, then every register at its top value with region wrapping
		foreach (directed_rows[i]) send_block(directed_rows[i], pick_gap());
		load_regs('1, '1, '1, '1, '1, '1, '1);
		foreach (directed_rows[i]) send_block(directed_rows[i], pick_gap());
		load_regs('0, '0, '0, '0, '0, '0, 64'd0);
		for (int i = 0; i < 4; i++) send_block(directed_rows[i], 0);

		for (int ph = 0; ph < 8; ph++) begin
			// region walks through every code, including out-of-range ones
			load_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
				{$urandom, 29'd0, 3'(ph)} );
			burst = (ph % 3 == 1);
			for (int n = 0; n < 85; n++) begin
				row.addr = (n % 10 == 0) ? 32'(rand64()) : $urandom;
				row.cl = rand64();
				row.ch = rand64();
				send_block(row, burst ? 0 : pick_gap());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_plain.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("covered %0d blocks in, %0d out, %0d register writes over 11 key settings",
			blocks_sent, blocks_seen, cfg_writes);
		if (errors == 0 && expected_plain.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
